// ===== sv/depth_pixel_unprojection_top_defines.svh =====
// Assertion macros for the checker file of the unprojection block.
`ifndef DEPTH_PIXEL_UNPROJECTION_TOP_DEFINES_SVH
`define DEPTH_PIXEL_UNPROJECTION_TOP_DEFINES_SVH

// Same-cycle implication, off while reset is asserted.
`define DPU_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("dpu assertion failed: same-cycle implication");

// Next-cycle implication, off while reset is asserted.
`define DPU_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("dpu assertion failed: next-cycle implication");

`endif

// ===== sv/dpu_pkg.sv =====
package dpu_pkg;

	// field widths
	localparam int DEPTH_W = 16;
	localparam int COORD_W = 24;
	localparam int COLOR_W = 8;
	localparam int DIM_CFG_W = 13;
	localparam int CENTER_W = 16;
	localparam int INV_W = 24;

	// fixed-point constants
	localparam int FRAC_BITS = 28;
	localparam int SAT_BIT = 52;
	localparam int RND_W = SAT_BIT - FRAC_BITS + 1;
	localparam logic [RND_W-1:0] COORD_POS_MAX = RND_W'(8388607);
	localparam logic [RND_W-1:0] COORD_NEG_MAX = RND_W'(8388608);
	localparam logic [COLOR_W-1:0] ALPHA_OPAQUE = 8'hFF;

	// decoupling queue
	localparam int FIFO_DEPTH = 4;

	// APB register map
	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;
	localparam logic [2:0] REG_IMAGE_WIDTH = 3'd0;
	localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd1;
	localparam logic [2:0] REG_CENTER_X = 3'd2;
	localparam logic [2:0] REG_CENTER_Y = 3'd3;
	localparam logic [2:0] REG_INV_FOCAL_X = 3'd4;
	localparam logic [2:0] REG_INV_FOCAL_Y = 3'd5;
	localparam logic [2:0] REG_COLOR_ENABLE = 3'd6;

	// reset values
	localparam logic [DIM_CFG_W-1:0] RST_IMAGE_WIDTH = 13'd640;
	localparam logic [DIM_CFG_W-1:0] RST_IMAGE_HEIGHT = 13'd480;
	localparam logic [CENTER_W-1:0] RST_CENTER_X = 16'd5120;
	localparam logic [CENTER_W-1:0] RST_CENTER_Y = 16'd3840;
	localparam logic [INV_W-1:0] RST_INV_FOCAL = 24'd31957;

	typedef struct packed {
		logic [DIM_CFG_W-1:0] image_width;
		logic [DIM_CFG_W-1:0] image_height;
		logic [CENTER_W-1:0] center_x;
		logic [CENTER_W-1:0] center_y;
		logic [INV_W-1:0] inv_focal_x;
		logic [INV_W-1:0] inv_focal_y;
		logic color_enable;
	} cfg_t;

	// classified pixel, as it leaves the front
	typedef struct packed {
		logic [DEPTH_W-1:0] depth;
		logic point_valid;
		logic [COLOR_W-1:0] red;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] blue;
		logic [COLOR_W-1:0] alpha;
		logic eof;
	} pix_t;

endpackage

// ===== sv/dpu_pixel_if.sv =====
interface dpu_pixel_if;
	logic valid;
	logic ready;
	logic [dpu_pkg::DEPTH_W-1:0] depth_mm;
	logic depth_missing;
	logic [dpu_pkg::COLOR_W-1:0] blue_in;
	logic [dpu_pkg::COLOR_W-1:0] green_in;
	logic [dpu_pkg::COLOR_W-1:0] red_in;

	modport source (output valid, depth_mm, depth_missing, blue_in, green_in, red_in,
		input ready);
	modport sink (input valid, depth_mm, depth_missing, blue_in, green_in, red_in,
		output ready);
endinterface

// ===== sv/dpu_point_if.sv =====
interface dpu_point_if;
	logic valid;
	logic ready;
	logic signed [dpu_pkg::COORD_W-1:0] x_mm;
	logic signed [dpu_pkg::COORD_W-1:0] y_mm;
	logic [dpu_pkg::DEPTH_W-1:0] z_mm;
	logic point_valid;
	logic [dpu_pkg::COLOR_W-1:0] red_out;
	logic [dpu_pkg::COLOR_W-1:0] green_out;
	logic [dpu_pkg::COLOR_W-1:0] blue_out;
	logic [dpu_pkg::COLOR_W-1:0] alpha_out;
	logic end_of_frame;

	modport source (output valid, x_mm, y_mm, z_mm, point_valid, red_out, green_out,
		blue_out, alpha_out, end_of_frame, input ready);
	modport sink (input valid, x_mm, y_mm, z_mm, point_valid, red_out, green_out,
		blue_out, alpha_out, end_of_frame, output ready);
endinterface

// ===== sv/dpu_cfg.sv =====
module dpu_cfg (
	input  logic clk,
	input  logic arst_n,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [dpu_pkg::ADDR_W-1:0] paddr,
	input  logic [dpu_pkg::DATA_W-1:0] pwdata,
	output logic [dpu_pkg::DATA_W-1:0] prdata,
	output logic pready,
	output dpu_pkg::cfg_t cfg
);

	dpu_pkg::cfg_t cfg_q;
	logic [2:0] idx;
	logic wr_en;

	assign idx = paddr[4:2];
	assign wr_en = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg = cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.image_width <= dpu_pkg::RST_IMAGE_WIDTH;
			cfg_q.image_height <= dpu_pkg::RST_IMAGE_HEIGHT;
			cfg_q.center_x <= dpu_pkg::RST_CENTER_X;
			cfg_q.center_y <= dpu_pkg::RST_CENTER_Y;
			cfg_q.inv_focal_x <= dpu_pkg::RST_INV_FOCAL;
			cfg_q.inv_focal_y <= dpu_pkg::RST_INV_FOCAL;
			cfg_q.color_enable <= 1'b1;
		end else if (wr_en) begin
			unique case (idx)
				dpu_pkg::REG_IMAGE_WIDTH: cfg_q.image_width <= pwdata[12:0];
				dpu_pkg::REG_IMAGE_HEIGHT: cfg_q.image_height <= pwdata[12:0];
				dpu_pkg::REG_CENTER_X: cfg_q.center_x <= pwdata[15:0];
				dpu_pkg::REG_CENTER_Y: cfg_q.center_y <= pwdata[15:0];
				dpu_pkg::REG_INV_FOCAL_X: cfg_q.inv_focal_x <= pwdata[23:0];
				dpu_pkg::REG_INV_FOCAL_Y: cfg_q.inv_focal_y <= pwdata[23:0];
				dpu_pkg::REG_COLOR_ENABLE: cfg_q.color_enable <= pwdata[0];
				default: ;
			endcase
		end
	end

	// read back
	always_comb begin
		unique case (idx)
			dpu_pkg::REG_IMAGE_WIDTH: prdata = 32'(cfg_q.image_width);
			dpu_pkg::REG_IMAGE_HEIGHT: prdata = 32'(cfg_q.image_height);
			dpu_pkg::REG_CENTER_X: prdata = 32'(cfg_q.center_x);
			dpu_pkg::REG_CENTER_Y: prdata = 32'(cfg_q.center_y);
			dpu_pkg::REG_INV_FOCAL_X: prdata = 32'(cfg_q.inv_focal_x);
			dpu_pkg::REG_INV_FOCAL_Y: prdata = 32'(cfg_q.inv_focal_y);
			dpu_pkg::REG_COLOR_ENABLE: prdata = 32'(cfg_q.color_enable);
			default: prdata = '0;
		endcase
	end

endmodule

// ===== sv/dpu_front.sv =====
module dpu_front #(
	parameter int MAX_DIM = 4096,
	parameter int CNT_W = 12
) (
	input  logic clk,
	input  logic arst_n,
	input  dpu_pkg::cfg_t cfg,
	dpu_pixel_if.sink pixel,
	input  logic fifo_full,
	output logic push,
	output logic [CNT_W-1:0] u,
	output logic [CNT_W-1:0] v,
	output dpu_pkg::pix_t pix
);

	localparam int DIM_W = $clog2(MAX_DIM + 1);
	localparam int LIM_W = (DIM_W > dpu_pkg::DIM_CFG_W) ? DIM_W : dpu_pkg::DIM_CFG_W;

	logic [CNT_W-1:0] col_q;
	logic [CNT_W-1:0] row_q;
	logic [LIM_W-1:0] w_lim;
	logic [LIM_W-1:0] h_lim;
	logic last_col;
	logic last_row;

	assign pixel.ready = ~fifo_full;
	assign push = pixel.valid & ~fifo_full;

	// clamp geometry to 1..MAX_DIM
	always_comb begin
		if (cfg.image_width == '0) begin
			w_lim = LIM_W'(1);
		end else if (LIM_W'(cfg.image_width) > LIM_W'(MAX_DIM)) begin
			w_lim = LIM_W'(MAX_DIM);
		end else begin
			w_lim = LIM_W'(cfg.image_width);
		end
		if (cfg.image_height == '0) begin
			h_lim = LIM_W'(1);
		end else if (LIM_W'(cfg.image_height) > LIM_W'(MAX_DIM)) begin
			h_lim = LIM_W'(MAX_DIM);
		end else begin
			h_lim = LIM_W'(cfg.image_height);
		end
	end

	// at-or-beyond test so a shrunk geometry wraps on the next pixel
	assign last_col = LIM_W'(col_q) >= (w_lim - LIM_W'(1));
	assign last_row = LIM_W'(row_q) >= (h_lim - LIM_W'(1));

	// classify the word
	always_comb begin
		u = col_q;
		v = row_q;
		pix.depth = pixel.depth_mm;
		pix.point_valid = (pixel.depth_mm != '0) & ~pixel.depth_missing;
		pix.red = cfg.color_enable ? pixel.red_in : '0;
		pix.green = cfg.color_enable ? pixel.green_in : '0;
		pix.blue = cfg.color_enable ? pixel.blue_in : '0;
		pix.alpha = cfg.color_enable ? dpu_pkg::ALPHA_OPAQUE : '0;
		pix.eof = last_col & last_row;
	end

	// raster counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (push) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + CNT_W'(1);
			end else begin
				col_q <= col_q + CNT_W'(1);
			end
		end
	end

endmodule

// ===== sv/dpu_fifo.sv =====
module dpu_fifo #(
	parameter int W = 8
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  logic [W-1:0] wdata,
	output logic full,
	input  logic pop,
	output logic [W-1:0] rdata,
	output logic not_empty
);

	localparam int PTR_W = $clog2(dpu_pkg::FIFO_DEPTH);

	logic [W-1:0] slot_q [dpu_pkg::FIFO_DEPTH];
	logic [PTR_W-1:0] wptr_q;
	logic [PTR_W-1:0] rptr_q;
	logic [PTR_W:0] cnt_q;
	logic do_pop;

	assign full = (cnt_q == (PTR_W+1)'(dpu_pkg::FIFO_DEPTH));
	assign not_empty = (cnt_q != '0);
	assign do_pop = pop & not_empty;
	assign rdata = slot_q[rptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wptr_q] <= wdata;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rptr_q <= rptr_q + PTR_W'(1);
			end
			unique case ({push, do_pop})
				2'b10: cnt_q <= cnt_q + (PTR_W+1)'(1);
				2'b01: cnt_q <= cnt_q - (PTR_W+1)'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== sv/dpu_back.sv =====
module dpu_back #(
	parameter int CNT_W = 12
) (
	input  logic clk,
	input  logic arst_n,
	input  dpu_pkg::cfg_t cfg,
	input  logic head_vld,
	input  logic [CNT_W-1:0] head_u,
	input  logic [CNT_W-1:0] head_v,
	input  dpu_pkg::pix_t head_pix,
	output logic pop,
	dpu_point_if.source point
);

	localparam int MAG_W = (CNT_W + 4 > dpu_pkg::CENTER_W) ? CNT_W + 4 : dpu_pkg::CENTER_W;
	localparam int T_W = MAG_W + dpu_pkg::DEPTH_W;
	localparam int SPLIT = T_W / 2;
	localparam int HI_W = T_W - SPLIT;
	localparam int LO_W = SPLIT + dpu_pkg::INV_W;
	localparam int PH_W = HI_W + dpu_pkg::INV_W;
	localparam int P_W = T_W + dpu_pkg::INV_W;
	localparam int RW = dpu_pkg::RND_W;

	logic adv;

	logic [1:0][CNT_W-1:0] pos;
	logic [1:0][MAG_W-1:0] p16;
	logic [1:0][MAG_W-1:0] ctr;
	logic [1:0][dpu_pkg::INV_W-1:0] inv;
	dpu_pkg::pix_t pix_in;

	logic vld_s1, vld_s2, vld_s3, vld_s4;
	dpu_pkg::pix_t pix_s1, pix_s2, pix_s3, pix_s4;
	logic [1:0] neg_s1, neg_s2, neg_s3, neg_s4;
	logic [1:0][MAG_W-1:0] mag_s1;
	logic [1:0][T_W-1:0] t_s2;
	logic [1:0][LO_W-1:0] pplo_s3;
	logic [1:0][PH_W-1:0] pphi_s3;
	logic [1:0][P_W-1:0] prod_s4;

	logic [1:0] sat;
	logic [1:0][RW:0] rsum;
	logic [1:0][RW-1:0] rnd;
	logic [1:0][RW-1:0] lim;
	logic [1:0][RW-1:0] magc;
	logic [1:0][RW-1:0] sgn;

	logic out_vld_q;
	dpu_pkg::pix_t out_pix_q;
	logic [1:0][dpu_pkg::COORD_W-1:0] coord_q;

	// whole pipe moves together, held only by a stalled output word
	assign adv = ~out_vld_q | point.ready;
	assign pop = adv & head_vld;

	// per-axis inputs: 0 is x, 1 is y
	always_comb begin
		pos[0] = head_u;
		pos[1] = head_v;
		ctr[0] = MAG_W'(cfg.center_x);
		ctr[1] = MAG_W'(cfg.center_y);
		inv[0] = cfg.inv_focal_x;
		inv[1] = cfg.inv_focal_y;
		for (int a = 0; a < 2; a++) begin
			p16[a] = MAG_W'({pos[a], 4'b0000});
		end
	end

	// depth zeroed for an invalid point
	always_comb begin
		pix_in = head_pix;
		if (!head_pix.point_valid) begin
			pix_in.depth = '0;
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			out_vld_q <= 1'b0;
		end else if (adv) begin
			vld_s1 <= head_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			out_vld_q <= vld_s4;
		end
	end

	// stage 1: signed offset in Q.4
	// stage 2: offset times depth
	// stage 3: split product with the reciprocal
	// stage 4: partial products summed
	always_ff @(posedge clk) begin
		if (adv) begin
			pix_s1 <= pix_in;
			for (int a = 0; a < 2; a++) begin
				neg_s1[a] <= p16[a] < ctr[a];
				mag_s1[a] <= (p16[a] < ctr[a]) ? (ctr[a] - p16[a]) : (p16[a] - ctr[a]);
			end

			pix_s2 <= pix_s1;
			neg_s2 <= neg_s1;
			for (int a = 0; a < 2; a++) begin
				t_s2[a] <= T_W'(mag_s1[a]) * T_W'(pix_s1.depth);
			end

			pix_s3 <= pix_s2;
			neg_s3 <= neg_s2;
			for (int a = 0; a < 2; a++) begin
				pplo_s3[a] <= LO_W'(t_s2[a][SPLIT-1:0]) * LO_W'(inv[a]);
				pphi_s3[a] <= PH_W'(t_s2[a][T_W-1:SPLIT]) * PH_W'(inv[a]);
			end

			pix_s4 <= pix_s3;
			neg_s4 <= neg_s3;
			for (int a = 0; a < 2; a++) begin
				prod_s4[a] <= P_W'(pplo_s3[a]) + (P_W'(pphi_s3[a]) << SPLIT);
			end
		end
	end

	// round half away from zero on the magnitude, saturate, apply sign
	always_comb begin
		for (int a = 0; a < 2; a++) begin
			sat[a] = |prod_s4[a][P_W-1:dpu_pkg::SAT_BIT];
			rsum[a] = (RW+1)'(prod_s4[a][dpu_pkg::SAT_BIT-1:dpu_pkg::FRAC_BITS-1])
				+ (RW+1)'(1);
			rnd[a] = rsum[a][RW:1];
			lim[a] = neg_s4[a] ? dpu_pkg::COORD_NEG_MAX : dpu_pkg::COORD_POS_MAX;
			magc[a] = (sat[a] || (rnd[a] > lim[a])) ? lim[a] : rnd[a];
			sgn[a] = neg_s4[a] ? (RW'(0) - magc[a]) : magc[a];
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (adv) begin
			out_pix_q <= pix_s4;
			for (int a = 0; a < 2; a++) begin
				coord_q[a] <= sgn[a][dpu_pkg::COORD_W-1:0];
			end
		end
	end

	assign point.valid = out_vld_q;
	assign point.x_mm = coord_q[0];
	assign point.y_mm = coord_q[1];
	assign point.z_mm = out_pix_q.depth;
	assign point.point_valid = out_pix_q.point_valid;
	assign point.red_out = out_pix_q.red;
	assign point.green_out = out_pix_q.green;
	assign point.blue_out = out_pix_q.blue;
	assign point.alpha_out = out_pix_q.alpha;
	assign point.end_of_frame = out_pix_q.eof;

endmodule

// ===== sv/depth_pixel_unprojection_top.sv =====
// Depth pixel unprojection to a 3D point cloud (pinhole camera model).
// Channel pixel: one raster-ordered depth word per transfer, with depth in mm,
// a missing flag and BGR colour; column and row come from internal counters
// that wrap at the configured image width and height.
// Channel point: one word per pixel with x, y, z in mm, a point-valid flag,
// RGBA colour and an end-of-frame flag on the last pixel of each frame.
// Both channels move a word on a clock edge with valid and ready high.
// Configuration: APB registers at byte address 4*index; write only when idle.
// Throughput: one pixel per clock; the front writes a 4-word queue and the
// back runs a five-register multiply pipeline that advances on each clock
// while its output register is empty or being taken.
// Receiver stall: the back pipeline holds, the queue fills, and pixel.ready
// falls once the queue holds four words.
// Reset (arst_n low): counters at row 0 column 0, queue and pipeline empty,
// registers at their reset values (640x480, center 320/240, color on).
module depth_pixel_unprojection_top #(
	parameter int MAX_DIM = 4096
) (
	input  logic clk,
	input  logic arst_n,
	dpu_pixel_if.sink pixel,
	dpu_point_if.source point,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [dpu_pkg::ADDR_W-1:0] paddr,
	input  logic [dpu_pkg::DATA_W-1:0] pwdata,
	output logic [dpu_pkg::DATA_W-1:0] prdata,
	output logic pready
);

	localparam int CNT_W = $clog2(MAX_DIM);
	localparam int ENT_W = 2 * CNT_W + $bits(dpu_pkg::pix_t);

	dpu_pkg::cfg_t cfg;
	logic fifo_full;
	logic push;
	logic pop;
	logic head_vld;
	logic [CNT_W-1:0] f_u, f_v;
	dpu_pkg::pix_t f_pix;
	logic [ENT_W-1:0] wdata;
	logic [ENT_W-1:0] rdata;
	logic [CNT_W-1:0] h_u, h_v;
	dpu_pkg::pix_t h_pix;

	dpu_cfg u_cfg (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
	);

	dpu_front #(.MAX_DIM(MAX_DIM), .CNT_W(CNT_W)) u_front (
		.clk(clk), .arst_n(arst_n), .cfg(cfg), .pixel(pixel), .fifo_full(fifo_full),
		.push(push), .u(f_u), .v(f_v), .pix(f_pix)
	);

	assign wdata = {f_u, f_v, f_pix};

	dpu_fifo #(.W(ENT_W)) u_fifo (
		.clk(clk), .arst_n(arst_n), .push(push), .wdata(wdata), .full(fifo_full),
		.pop(pop), .rdata(rdata), .not_empty(head_vld)
	);

	assign {h_u, h_v, h_pix} = rdata;

	dpu_back #(.CNT_W(CNT_W)) u_back (
		.clk(clk), .arst_n(arst_n), .cfg(cfg), .head_vld(head_vld), .head_u(h_u),
		.head_v(h_v), .head_pix(h_pix), .pop(pop), .point(point)
	);

endmodule

// ===== sv/dpu_checker.sv =====
`include "depth_pixel_unprojection_top_defines.svh"

module dpu_checker (
	input logic clk,
	input logic arst_n,
	input logic point_valid_hs,
	input logic point_ready,
	input logic [23:0] x_mm,
	input logic [23:0] y_mm,
	input logic [15:0] z_mm,
	input logic point_valid,
	input logic [7:0] red_out,
	input logic [7:0] green_out,
	input logic [7:0] blue_out,
	input logic [7:0] alpha_out
);

	// a stalled word holds
	`DPU_ASSERT_NXT(a_point_hold, clk, arst_n, point_valid_hs && !point_ready, point_valid_hs && $stable(x_mm) && $stable(y_mm) && $stable(z_mm))

	// invalid point carries a zero position
	`DPU_ASSERT_IMP(a_invalid_zero, clk, arst_n, point_valid_hs && !point_valid, x_mm == 24'd0 && y_mm == 24'd0 && z_mm == 16'd0)

	// valid point has a nonzero depth
	`DPU_ASSERT_IMP(a_valid_depth, clk, arst_n, point_valid_hs && point_valid, z_mm != 16'd0)

	// alpha is either opaque or zero
	`DPU_ASSERT_IMP(a_alpha_code, clk, arst_n, point_valid_hs, alpha_out == 8'hFF || alpha_out == 8'h00)

	// colour off clears all channels
	`DPU_ASSERT_IMP(a_color_off, clk, arst_n, point_valid_hs && alpha_out == 8'h00, red_out == 8'd0 && green_out == 8'd0 && blue_out == 8'd0)

endmodule

bind depth_pixel_unprojection_top dpu_checker u_dpu_checker (
	.clk(clk),
	.arst_n(arst_n),
	.point_valid_hs(point.valid),
	.point_ready(point.ready),
	.x_mm(point.x_mm),
	.y_mm(point.y_mm),
	.z_mm(point.z_mm),
	.point_valid(point.point_valid),
	.red_out(point.red_out),
	.green_out(point.green_out),
	.blue_out(point.blue_out),
	.alpha_out(point.alpha_out)
);
